/* src/huffman_code_bit_packer_defines.svh */
// Assertion macros shared by the Huffman bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define HCBP_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication outside reset.
`define HCBP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* src/hcbp_pkg.sv */
// Constants and request codes for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;
   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 8;
   localparam int PEND_W       = 7;
   localparam int ACC_W        = PEND_W + CODE_W;
   localparam int TOTAL_W      = 6;
   localparam int ENTRY_W      = CODE_W + LEN_W;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 16;
   // stored code length limit: the cap, but never more than the code field holds
   localparam int LEN_CAP      = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ENCODE = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;
endpackage
`default_nettype wire

/* src/huffman_code_bit_packer.sv */
// Huffman encoder back end: loadable code table and output bit packer.
//
// Load transfers write one code table entry (code and length, length capped at
// MAX_CODE_LEN). Encode transfers look their symbol up in the table and append
// the code, first bit first, to the pending bit buffer; every completed byte
// leaves as one rsp transfer, first code bit in bit 7. A flush pads the last
// partial byte with zeros, sends it with the pad count and tlast, and leaves the
// packer empty; a flush on a byte boundary sends nothing. The table lives in a
// single-port-write, single-port-read RAM with registered read data: the lookup
// is issued on the accepting edge and the entry is merged into the bit buffer
// when the lookup stage is taken, so a load is visible to an encode accepted
// right after it. Rate: an encode that completes k bytes (k is at most 4) sends
// them one per cycle while rsp is ready, and encodes that complete no more than
// one byte are then accepted every cycle, because merging overlaps the final
// byte of the previous item. A flush waits until fewer than eight bits are
// pending and, if any are, the output is free. An encode's bytes pass the lookup
// register, bit buffer and output register; a flush byte goes from the lookup
// stage to the output register. The emitter's one-byte-per-cycle drain sets the
// throughput. Table entries that were never loaded read back as don't-care.
`default_nettype none
`include "huffman_code_bit_packer_defines.svh"
module huffman_code_bit_packer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [7:0] entry_index, [39:8] entry_code, [45:40] entry_length,
   // [53:46] data_byte, [55:54] zero
   input  wire logic [hcbp_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [7:0] out_byte, [10:8] pad_count, [15:11] zero
   output logic [hcbp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import hcbp_pkg::*;

   // request field unpack
   logic [SYM_W-1:0]  entry_index;
   logic [CODE_W-1:0] entry_code;
   logic [LEN_W-1:0]  entry_length;
   logic [SYM_W-1:0]  data_byte;
   logic [LEN_W-1:0]  len_capped;
   logic              req_fire;

   assign entry_index  = req_tdata[7:0];
   assign entry_code   = req_tdata[39:8];
   assign entry_length = req_tdata[45:40];
   assign data_byte    = req_tdata[53:46];
   assign req_fire     = req_tvalid && req_tready;

   assign len_capped = (entry_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                         : entry_length;

   // code table RAM: {length, code}
   logic [ENTRY_W-1:0] table_mem [SYMBOL_COUNT];
   logic [ENTRY_W-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == REQ_LOAD &&
          ({1'b0, entry_index} < 9'(SYMBOL_COUNT))) begin
         table_mem[entry_index[$clog2(SYMBOL_COUNT)-1:0]] <= {len_capped, entry_code};
      end
      if (req_fire) begin
         rd_q_ff <= table_mem[data_byte[$clog2(SYMBOL_COUNT)-1:0]];
      end
   end

   // lookup stage
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_type_ff;
   logic       s1_inrange_ff;
   logic       s1_take;

   // emitter: pending bits plus bits of the current code still to send
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [2:0] pad_ff, pad_in;
   logic       last_ff, last_in;

   logic               out_free;
   logic               emit_now;
   logic               idle_next;
   logic               flush_ok;
   logic [TOTAL_W-1:0] base_total;
   logic [PEND_W-1:0]  base_bits;
   logic [LEN_W-1:0]   s1_len;
   logic [CODE_W:0]    code_mask;
   logic [CODE_W-1:0]  s1_code;
   logic [ACC_W-1:0]   merged_acc;
   logic [TOTAL_W-1:0] merged_total;
   logic [7:0]         emit_byte;
   logic [2:0]         flush_pad;
   logic [14:0]        flush_wide;
   logic [7:0]         flush_byte;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit_now  = (total_ff >= TOTAL_W'(8)) && out_free;
   assign idle_next = (total_ff < TOTAL_W'(8)) || ((total_ff < TOTAL_W'(16)) && out_free);
   assign flush_ok  = (total_ff < TOTAL_W'(8)) && ((total_ff == '0) || out_free);

   assign base_total = emit_now ? (total_ff - TOTAL_W'(8)) : total_ff;
   assign base_bits  = acc_ff[PEND_W-1:0] & ~({PEND_W{1'b1}} << base_total[2:0]);

   assign s1_len    = s1_inrange_ff ? rd_q_ff[ENTRY_W-1:CODE_W] : '0;
   assign code_mask = ~({(CODE_W+1){1'b1}} << s1_len);
   assign s1_code   = rd_q_ff[CODE_W-1:0] & code_mask[CODE_W-1:0];

   assign merged_acc   = (ACC_W'(base_bits) << s1_len) | ACC_W'(s1_code);
   assign merged_total = base_total + TOTAL_W'(s1_len);

   assign emit_byte = 8'(acc_ff >> (total_ff - TOTAL_W'(8)));

   // flush byte: pending bits moved up against bit 7
   assign flush_pad  = 3'(4'd8 - {1'b0, total_ff[2:0]});
   assign flush_wide = {8'd0, acc_ff[PEND_W-1:0]} << flush_pad;
   assign flush_byte = flush_wide[7:0];

   always_comb begin
      case (s1_type_ff)
         REQ_ENCODE: s1_take = s1_valid_ff && idle_next;
         REQ_FLUSH:  s1_take = s1_valid_ff && flush_ok;
         default:    s1_take = s1_valid_ff;
      endcase
   end

   assign req_tready  = !s1_valid_ff || s1_take;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_take);

   always_comb begin
      acc_in   = acc_ff;
      total_in = total_ff;
      if (s1_take && s1_type_ff == REQ_ENCODE) begin
         acc_in   = merged_acc;
         total_in = merged_total;
      end else if (s1_take && s1_type_ff == REQ_FLUSH) begin
         total_in = '0;
      end else if (emit_now) begin
         total_in = total_ff - TOTAL_W'(8);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      pad_in       = pad_ff;
      last_in      = last_ff;
      if (emit_now) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         pad_in       = '0;
         last_in      = 1'b0;
      end else if (s1_take && s1_type_ff == REQ_FLUSH && total_ff != '0) begin
         out_valid_in = 1'b1;
         out_byte_in  = flush_byte;
         pad_in       = flush_pad;
         last_in      = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff    <= req_tuser;
         s1_inrange_ff <= {1'b0, data_byte} < 9'(SYMBOL_COUNT);
      end
      acc_ff      <= acc_in;
      out_byte_ff <= out_byte_in;
      pad_ff      <= pad_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, pad_ff, out_byte_ff};
   assign rsp_tlast  = last_ff;

   `HCBP_ASSERT_ALWAYS(a_total_range, total_ff <= TOTAL_W'(ACC_W), "bit count overflow")
   `HCBP_ASSERT_IMPLY(a_merge_drained, s1_take && s1_type_ff == REQ_ENCODE,
      total_ff < TOTAL_W'(16) && (total_ff < TOTAL_W'(8) || emit_now), "merge over full bytes")
   `HCBP_ASSERT_IMPLY(a_last_pad, out_valid_ff && last_ff, pad_ff != '0, "last without pad")
   `HCBP_ASSERT_IMPLY(a_mid_pad, out_valid_ff && !last_ff, pad_ff == '0, "pad on middle byte")
endmodule
`default_nettype wire

/* sim/tb_huffman_code_bit_packer.sv */
// Testbench for huffman_code_bit_packer: directed table plus random streams.
module tb_huffman_code_bit_packer;
   import hcbp_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;   // no such request, block must ignore it
   localparam int DRAIN_CYCLES = 16;           // extra wait before the final missing-byte check
   localparam int HOLD_CYCLES  = 300;          // long receiver stall to fill the block up
   localparam int RAND_PER_PHASE = 170;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] pad_count;
      logic       is_last;
   } packed_byte_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  idx;
      logic [31:0] code;
      logic [5:0]  len;
      logic [7:0]  sym;
      bit          typed;     // expectation written in the row, not predicted
      int          n_typed;   // 0 or 1 result
      packed_byte_type typed_byte;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = REQ_LOAD;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   huffman_code_bit_packer uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: the code table and the partial byte
   logic [31:0] tab_code [SYMBOL_COUNT];
   logic [5:0]  tab_len  [SYMBOL_COUNT];
   bit          tab_loaded [SYMBOL_COUNT];
   int          loaded_syms [$];
   logic [6:0]  pend_bits = '0;
   logic [2:0]  pend_cnt  = '0;

   packed_byte_type step_bytes [$];       // bytes caused by the latest item
   packed_byte_type expected_bytes [$];   // bytes still owed by the block

   int errors = 0;
   int n_results = 0;
   int n_load = 0, n_encode = 0, n_flush = 0, n_other = 0;
   int req_idle_pct = 16;
   int rsp_idle_pct = 59;
   int hold_asked = 0;
   int hold_served = 0;

   dir_row_type dir_rows [$];

   function automatic int code_cap();
      return (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
   endfunction

   // Work out the bytes one request produces and advance the packer state.
   task automatic pack_request(input logic [1:0] kind, input logic [7:0] idx,
                               input logic [31:0] code, input logic [5:0] len,
                               input logic [7:0] sym);
      int l;
      int total;
      int pad;
      logic [63:0] acc;
      logic [63:0] mask;
      packed_byte_type b;
      step_bytes.delete();
      case (kind)
         REQ_LOAD: begin
            if (idx < SYMBOL_COUNT) begin
               l = int'(len);
               if (l > code_cap()) l = code_cap();
               tab_code[idx] = code;
               tab_len[idx]  = l[5:0];
               if (!tab_loaded[idx]) begin
                  tab_loaded[idx] = 1'b1;
                  loaded_syms.push_back(int'(idx));
               end
            end
         end
         REQ_ENCODE: begin
            l = 0;
            acc = '0;
            if (sym < SYMBOL_COUNT) begin
               l = int'(tab_len[sym]);
               if (l > code_cap()) l = code_cap();
               mask = (64'd1 << l) - 64'd1;
               acc = {32'd0, tab_code[sym]} & mask;
            end
            acc = ({57'd0, pend_bits} << l) | acc;
            total = int'(pend_cnt) + l;
            while (total >= 8) begin
               total -= 8;
               b.out_byte  = 8'(acc >> total);
               b.pad_count = '0;
               b.is_last   = 1'b0;
               step_bytes.push_back(b);
            end
            mask = (64'd1 << total) - 64'd1;
            pend_bits = 7'(acc & mask);
            pend_cnt  = 3'(total);
         end
         REQ_FLUSH: begin
            if (pend_cnt != 0) begin
               pad = (8 - int'(pend_cnt)) % 8;
               b.out_byte  = {1'b0, pend_bits} << pad;
               b.pad_count = 3'(pad);
               b.is_last   = 1'b1;
               step_bytes.push_back(b);
            end
            pend_bits = '0;
            pend_cnt  = '0;
         end
         default: ;
      endcase
   endtask

   // Offer one request and return at the edge that accepts it; tvalid stays high.
   task automatic send_request(input logic [1:0] kind, input logic [7:0] idx,
                               input logic [31:0] code, input logic [5:0] len,
                               input logic [7:0] sym);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {2'b00, sym, len, code, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      case (kind)
         REQ_LOAD:   n_load++;
         REQ_ENCODE: n_encode++;
         REQ_FLUSH:  n_flush++;
         default:    n_other++;
      endcase
   endtask

   // Predict, queue the expectation, then transfer the request.
   task automatic issue_predicted(input logic [1:0] kind, input logic [7:0] idx,
                                  input logic [31:0] code, input logic [5:0] len,
                                  input logic [7:0] sym);
      pack_request(kind, idx, code, len, sym);
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      send_request(kind, idx, code, len, sym);
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [7:0] idx,
                          input logic [31:0] code, input logic [5:0] len,
                          input logic [7:0] sym, input bit typed, input int n_typed,
                          input logic [7:0] t_byte, input logic [2:0] t_pad,
                          input logic t_last);
      dir_row_type r;
      r.kind = kind; r.idx = idx; r.code = code; r.len = len; r.sym = sym;
      r.typed = typed; r.n_typed = n_typed;
      r.typed_byte.out_byte = t_byte;
      r.typed_byte.pad_count = t_pad;
      r.typed_byte.is_last = t_last;
      dir_rows.push_back(r);
   endtask

   task automatic wait_all_received();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // One random request; mostly encodes of loaded symbols, with loads, flushes and unused codes mixed in.
   task automatic random_request();
      int r;
      int lr;
      logic [1:0]  kind;
      logic [7:0]  idx;
      logic [31:0] code;
      logic [5:0]  len;
      logic [7:0]  sym;
      r    = $urandom_range(99);
      idx  = 8'($urandom_range(255));
      code = $urandom;
      len  = 6'($urandom_range(63));
      sym  = 8'($urandom_range(255));
      if (r < 14 || loaded_syms.size() == 0) begin
         kind = REQ_LOAD;
         lr = $urandom_range(99);
         if (lr < 10)      len = 0;
         else if (lr < 70) len = 6'($urandom_range(12, 1));
         else if (lr < 90) len = 6'($urandom_range(32, 13));
         else              len = 6'($urandom_range(63, 33));
      end else if (r < 84) begin
         kind = REQ_ENCODE;
         // never encode a symbol whose table entry was never written
         sym = 8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
      end else if (r < 95) begin
         kind = REQ_FLUSH;
      end else begin
         kind = REQ_UNUSED;
      end
      issue_predicted(kind, idx, code, len, sym);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin : rsp_sink
      int k;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served++;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Result checker: every rsp transfer against the oldest expected byte
   packed_byte_type want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTS)
               $display("%0t: rsp transfer with nothing expected: byte %h pad %0d last %b",
                        $time, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tlast);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte) begin
               errors++;
               if (errors <= MAX_PRINTS)
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.out_byte, rsp_tdata[7:0]);
            end
            if (rsp_tdata[10:8] !== want.pad_count) begin
               errors++;
               if (errors <= MAX_PRINTS)
                  $display("%0t: pad_count expected %0d actual %0d",
                           $time, want.pad_count, rsp_tdata[10:8]);
            end
            if (rsp_tlast !== want.is_last) begin
               errors++;
               if (errors <= MAX_PRINTS)
                  $display("%0t: last expected %b actual %b",
                           $time, want.is_last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // kind, idx, code, len, sym, typed, n, byte, pad, last
      add_row(REQ_FLUSH,  8'd0,   32'h0,         6'd0,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'd63, 8'hFF,  1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd8,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd0,   1, 1, 8'hFF, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd0,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      // zero-length code leaves the packer as it was
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd255, 1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd1,   32'h1,         6'd1,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd1,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_FLUSH,  8'd0,   32'h0,         6'd0,  8'd0,   1, 1, 8'h80, 3'd7, 1'b1);
      // overlong length saturates to the cap
      add_row(REQ_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd63, 8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd2,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd3,   32'h7F,        6'd7,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd3,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd4,   32'hAAAA_5555, 6'd32, 8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      // seven pending bits plus a full-length code
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd4,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_FLUSH,  8'd0,   32'h0,         6'd0,  8'd0,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd5,   32'h1234_5678, 6'd40, 8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      // code bits above the length must be dropped
      add_row(REQ_LOAD,   8'd6,   32'hFFFF_FF05, 6'd4,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd6,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd5,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd1,   0, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_FLUSH,  8'd0,   32'h0,         6'd0,  8'd0,   0, 0, 8'h00, 3'd0, 1'b0);
      // flush on a byte boundary sends nothing
      add_row(REQ_FLUSH,  8'd0,   32'h0,         6'd0,  8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_LOAD,   8'd7,   32'h0,         6'd32, 8'd0,   1, 0, 8'h00, 3'd0, 1'b0);
      add_row(REQ_ENCODE, 8'd0,   32'h0,         6'd0,  8'd7,   0, 0, 8'h00, 3'd0, 1'b0);

      foreach (dir_rows[i]) begin
         pack_request(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].code,
                      dir_rows[i].len, dir_rows[i].sym);
         if (dir_rows[i].typed) begin
            if (dir_rows[i].n_typed != 0) expected_bytes.push_back(dir_rows[i].typed_byte);
         end else begin
            foreach (step_bytes[j]) expected_bytes.push_back(step_bytes[j]);
         end
         send_request(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].code,
                      dir_rows[i].len, dir_rows[i].sym);
      end

      // phase one: sender mostly busy, receiver often stalled
      req_idle_pct = 16;
      rsp_idle_pct = 59;
      repeat (RAND_PER_PHASE) random_request();

      // phase two: roles swapped, opened with a long receiver hold-off
      req_idle_pct = 59;
      rsp_idle_pct = 16;
      hold_asked++;
      repeat (RAND_PER_PHASE) random_request();

      // sender pauses until the block has delivered everything
      wait_all_received();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (RAND_PER_PHASE) random_request();
      req_tvalid <= 1'b0;

      waited = 0;
      while (expected_bytes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         errors += expected_bytes.size();
         $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      end

      $display("covered %0d loads, %0d encodes, %0d flushes, %0d unknown requests",
               n_load, n_encode, n_flush, n_other);
      $display("checked %0d output bytes under three stall mixes and a long hold-off",
               n_results);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

/* huffman_code_bit_packer.f */
+incdir+src
src/hcbp_pkg.sv
src/huffman_code_bit_packer.sv
sim/tb_huffman_code_bit_packer.sv
